FILE: design/rmg_pkg.sv
// Shared types, codes, constants and table functions of the revolution mesh generator.
// Used by rmg_emit and revolution_mesh_generator_core; depends on nothing else.
package rmg_pkg;

  localparam int MAX_POINTS   = 256;
  localparam int MAX_SAMPLES  = 256;
  localparam int QUAD_RESULTS = 6;
  localparam int DEG_FULL     = 360;
  localparam int DEG_HALF     = 180;
  localparam int DEG_3QUARTER = 270;
  localparam int DEG_QUARTER  = 90;
  localparam int TRIG_FRAC    = 14;
  localparam int ROUND_HALF   = 8192;
  localparam int QUO_W        = 9;
  localparam int DIV_STEP     = 3;

  // Operation and result kind codes.
  localparam logic OP_VERTEX = 1'b0;
  localparam logic OP_QUAD   = 1'b1;

  // Configuration register indexes.
  localparam logic REG_PROFILE_POINTS   = 1'b0;
  localparam logic REG_ROTATION_SAMPLES = 1'b1;

  typedef struct packed {
    logic [17:0]      rem;
    logic [QUO_W-1:0] quo;
  } div_state_t;

  // One finished item as handed to the output stage.
  typedef struct packed {
    logic               kind;
    logic               bad;
    logic [15:0]        vnum;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic [15:0]        a;
    logic [15:0]        idx1;
    logic [15:0]        idx2;
  } emit_item_t;

  // Three quotient bits of a restoring division, starting at top_bit.
  function automatic div_state_t div_3bits(div_state_t cur, logic [8:0] dvs,
                                           int unsigned top_bit);
    div_state_t  r;
    logic [17:0] trial;
    r = cur;
    for (int b = 0; b < DIV_STEP; b++) begin
      trial = 18'(dvs) << (top_bit - b);
      if (r.rem >= trial) begin
        r.rem = r.rem - trial;
        r.quo = r.quo | (QUO_W'(1) << (top_bit - b));
      end
    end
    return r;
  endfunction

  // Quarter-wave sine in Q1.14, whole degrees 0 to 90.
  function automatic logic [14:0] sin_tab(logic [6:0] d);
    logic [14:0] v;
    case (d)
      7'd0: v = 15'd0;       7'd1: v = 15'd286;     7'd2: v = 15'd572;
      7'd3: v = 15'd857;     7'd4: v = 15'd1143;    7'd5: v = 15'd1428;
      7'd6: v = 15'd1713;    7'd7: v = 15'd1997;    7'd8: v = 15'd2280;
      7'd9: v = 15'd2563;    7'd10: v = 15'd2845;   7'd11: v = 15'd3126;
      7'd12: v = 15'd3406;   7'd13: v = 15'd3686;   7'd14: v = 15'd3964;
      7'd15: v = 15'd4240;   7'd16: v = 15'd4516;   7'd17: v = 15'd4790;
      7'd18: v = 15'd5063;   7'd19: v = 15'd5334;   7'd20: v = 15'd5604;
      7'd21: v = 15'd5872;   7'd22: v = 15'd6138;   7'd23: v = 15'd6402;
      7'd24: v = 15'd6664;   7'd25: v = 15'd6924;   7'd26: v = 15'd7182;
      7'd27: v = 15'd7438;   7'd28: v = 15'd7692;   7'd29: v = 15'd7943;
      7'd30: v = 15'd8192;   7'd31: v = 15'd8438;   7'd32: v = 15'd8682;
      7'd33: v = 15'd8923;   7'd34: v = 15'd9162;   7'd35: v = 15'd9397;
      7'd36: v = 15'd9630;   7'd37: v = 15'd9860;   7'd38: v = 15'd10087;
      7'd39: v = 15'd10311;  7'd40: v = 15'd10531;  7'd41: v = 15'd10749;
      7'd42: v = 15'd10963;  7'd43: v = 15'd11174;  7'd44: v = 15'd11381;
      7'd45: v = 15'd11585;  7'd46: v = 15'd11786;  7'd47: v = 15'd11983;
      7'd48: v = 15'd12176;  7'd49: v = 15'd12365;  7'd50: v = 15'd12551;
      7'd51: v = 15'd12733;  7'd52: v = 15'd12911;  7'd53: v = 15'd13085;
      7'd54: v = 15'd13255;  7'd55: v = 15'd13421;  7'd56: v = 15'd13583;
      7'd57: v = 15'd13741;  7'd58: v = 15'd13894;  7'd59: v = 15'd14044;
      7'd60: v = 15'd14189;  7'd61: v = 15'd14330;  7'd62: v = 15'd14466;
      7'd63: v = 15'd14598;  7'd64: v = 15'd14726;  7'd65: v = 15'd14849;
      7'd66: v = 15'd14968;  7'd67: v = 15'd15082;  7'd68: v = 15'd15191;
      7'd69: v = 15'd15296;  7'd70: v = 15'd15396;  7'd71: v = 15'd15491;
      7'd72: v = 15'd15582;  7'd73: v = 15'd15668;  7'd74: v = 15'd15749;
      7'd75: v = 15'd15826;  7'd76: v = 15'd15897;  7'd77: v = 15'd15964;
      7'd78: v = 15'd16026;  7'd79: v = 15'd16083;  7'd80: v = 15'd16135;
      7'd81: v = 15'd16182;  7'd82: v = 15'd16225;  7'd83: v = 15'd16262;
      7'd84: v = 15'd16294;  7'd85: v = 15'd16322;  7'd86: v = 15'd16344;
      7'd87: v = 15'd16362;  7'd88: v = 15'd16374;  7'd89: v = 15'd16382;
      7'd90: v = 15'd16384;
      default: v = 15'd0;
    endcase
    return v;
  endfunction

  // Signed Q1.14 sine of a whole-degree angle in the range 0 to 359.
  function automatic logic signed [15:0] sin_deg(logic [8:0] d);
    logic [14:0] mag;
    logic        neg;
    if (d <= 9'(DEG_QUARTER)) begin
      mag = sin_tab(7'(d));
      neg = 1'b0;
    end else if (d <= 9'(DEG_HALF)) begin
      mag = sin_tab(7'(9'(DEG_HALF) - d));
      neg = 1'b0;
    end else if (d <= 9'(DEG_3QUARTER)) begin
      mag = sin_tab(7'(d - 9'(DEG_HALF)));
      neg = 1'b1;
    end else begin
      mag = sin_tab(7'(9'(DEG_FULL) - d));
      neg = 1'b1;
    end
    return neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

endpackage

FILE: design/revolution_mesh_generator_core.sv
// An item passes stage registers s1 to s6, then the rmg_emit output register; one item
// per cycle unless the output stalls. A vertex or bad item gives one transfer, a quad
// six, one per cycle while out_tready is high, holding the pipeline for the other five.
// The angle comes from a three-stage restoring divider (three quotient bits a stage).
// Reset is synchronous and active low: it empties the pipeline and sets the point and
// sample counts to 16 and 3.
module revolution_mesh_generator_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [8:0]   cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // sample_number, point_number, point_x, point_y, point_z (lowest bit first)
  input  logic [111:0] in_tdata,
  // operation
  input  logic [0:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // vertex_number, vertex_x, vertex_y, vertex_z, triangle_vertex (lowest bit first)
  output logic [127:0] out_tdata,
  // result_kind, bad_request (lowest bit first)
  output logic [1:0]   out_tuser,
  output logic         out_tlast
);

  // One stage record; each stage fills in the fields that its step produces and the
  // rest ride along unchanged.
  typedef struct packed {
    logic               op;
    logic               bad;
    logic [7:0]         smp;
    logic [7:0]         pnt;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    rmg_pkg::div_state_t div;
    logic [16:0]        a;
    logic [16:0]        total;
    logic [15:0]        idx1;
    logic [15:0]        idx2;
    logic signed [15:0] s;
    logic signed [15:0] c;
    logic signed [47:0] pcx;
    logic signed [47:0] psz;
    logic signed [47:0] psx;
    logic signed [47:0] pcz;
  } pipe_t;

  logic [8:0]          points_r;
  logic [8:0]          samples_r;
  logic [8:0]          m_eff;
  logic [8:0]          n_eff;
  logic                en;
  logic [5:0]          v_r;
  pipe_t               s1_r, s2_r, s3_r, s4_r, s5_r, s6_r;
  pipe_t               s1_nxt, s2_nxt, s3_nxt, s4_nxt, s5_nxt, s6_nxt;
  logic [9:0]          theta_90;
  logic [8:0]          cos_arg;
  logic [16:0]         sum1, sum2;
  logic signed [48:0]  acc_x, acc_z;
  logic signed [34:0]  sh_x, sh_z;
  logic signed [31:0]  sat_x, sat_z;
  rmg_pkg::emit_item_t item;

  // Configuration registers. Writes must come only while the block is idle; the block
  // does not enforce it. Every stage reads the current counts directly.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      points_r  <= 9'd16;
      samples_r <= 9'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        rmg_pkg::REG_PROFILE_POINTS:   points_r  <= cfg_wdata;
        rmg_pkg::REG_ROTATION_SAMPLES: samples_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Counts above the supported maximum behave as the maximum.
  assign m_eff = (points_r > 9'(rmg_pkg::MAX_POINTS)) ? 9'(rmg_pkg::MAX_POINTS) : points_r;
  assign n_eff = (samples_r > 9'(rmg_pkg::MAX_SAMPLES)) ? 9'(rmg_pkg::MAX_SAMPLES)
                                                         : samples_r;

  // The whole pipeline moves in step whenever the output register can take an item.
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 6'd0;
    end else if (en) begin
      v_r <= {v_r[4:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
      s3_r <= s3_nxt;
      s4_r <= s4_nxt;
      s5_r <= s5_nxt;
      s6_r <= s6_nxt;
    end
  end

  // Stage 1: capture the fields, check the range and form the dividend i*360.
  always_comb begin
    s1_nxt     = '0;
    s1_nxt.op  = in_tuser[0];
    s1_nxt.smp = in_tdata[7:0];
    s1_nxt.pnt = in_tdata[15:8];
    s1_nxt.x   = in_tdata[47:16];
    s1_nxt.y   = in_tdata[79:48];
    s1_nxt.z   = in_tdata[111:80];
    if (in_tuser[0] == rmg_pkg::OP_VERTEX) begin
      s1_nxt.bad = ({1'b0, in_tdata[7:0]} >= n_eff) || ({1'b0, in_tdata[15:8]} >= m_eff);
    end else begin
      s1_nxt.bad = ({1'b0, in_tdata[7:0]} >= n_eff) ||
                   (({1'b0, in_tdata[15:8]} + 9'd1) >= m_eff);
    end
    s1_nxt.div.rem = 18'(17'(in_tdata[7:0]) * 17'(rmg_pkg::DEG_FULL));
  end

  // Stage 2: top quotient bits, vertex index a = i*m+j and the total T = n*m.
  always_comb begin
    s2_nxt       = s1_r;
    s2_nxt.div   = rmg_pkg::div_3bits(s1_r.div, n_eff, rmg_pkg::QUO_W - 1);
    s2_nxt.a     = 17'(17'(s1_r.smp) * 17'(m_eff)) + 17'(s1_r.pnt);
    s2_nxt.total = 17'(17'(n_eff) * 17'(m_eff));
  end

  // Stage 3: middle quotient bits and the wrapped neighbour indices. a stays below T
  // for a good request, so one subtraction of T completes each modulo.
  always_comb begin
    s3_nxt      = s2_r;
    s3_nxt.div  = rmg_pkg::div_3bits(s2_r.div, n_eff,
                                     rmg_pkg::QUO_W - 1 - rmg_pkg::DIV_STEP);
    sum1        = s2_r.a + 17'(m_eff);
    sum2        = sum1 + 17'd1;
    s3_nxt.idx1 = 16'((sum1 >= s2_r.total) ? (sum1 - s2_r.total) : sum1);
    s3_nxt.idx2 = 16'((sum2 >= s2_r.total) ? (sum2 - s2_r.total) : sum2);
  end

  // Stage 4: last quotient bits give the angle in whole degrees.
  always_comb begin
    s4_nxt     = s3_r;
    s4_nxt.div = rmg_pkg::div_3bits(s3_r.div, n_eff,
                                    rmg_pkg::QUO_W - 1 - 2 * rmg_pkg::DIV_STEP);
  end

  // Stage 5: sine and cosine from the quarter-wave table.
  always_comb begin
    s5_nxt   = s4_r;
    theta_90 = 10'(s4_r.div.quo) + 10'(rmg_pkg::DEG_QUARTER);
    cos_arg  = (theta_90 >= 10'(rmg_pkg::DEG_FULL)) ? 9'(theta_90 - 10'(rmg_pkg::DEG_FULL))
                                                     : 9'(theta_90);
    s5_nxt.s = rmg_pkg::sin_deg(s4_r.div.quo);
    s5_nxt.c = rmg_pkg::sin_deg(cos_arg);
  end

  // Stage 6: the four exact products.
  always_comb begin
    s6_nxt     = s5_r;
    s6_nxt.pcx = 48'(s5_r.c) * 48'(s5_r.x);
    s6_nxt.psz = 48'(s5_r.s) * 48'(s5_r.z);
    s6_nxt.psx = 48'(s5_r.s) * 48'(s5_r.x);
    s6_nxt.pcz = 48'(s5_r.c) * 48'(s5_r.z);
  end

  // Sums, round half up by adding a half and shifting toward minus infinity, then
  // saturate to 32 bits when the upper bits are not all copies of the sign.
  always_comb begin
    acc_x = 49'(s6_r.pcx) + 49'(s6_r.psz) + 49'(rmg_pkg::ROUND_HALF);
    acc_z = 49'(s6_r.pcz) - 49'(s6_r.psx) + 49'(rmg_pkg::ROUND_HALF);
    sh_x  = 35'(acc_x >>> rmg_pkg::TRIG_FRAC);
    sh_z  = 35'(acc_z >>> rmg_pkg::TRIG_FRAC);
    if (sh_x[34:31] == 4'b0000 || sh_x[34:31] == 4'b1111) begin
      sat_x = sh_x[31:0];
    end else begin
      sat_x = sh_x[34] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    if (sh_z[34:31] == 4'b0000 || sh_z[34:31] == 4'b1111) begin
      sat_z = sh_z[31:0];
    end else begin
      sat_z = sh_z[34] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end

    item      = '0;
    item.kind = s6_r.op;
    item.bad  = s6_r.bad;
    if (!s6_r.bad) begin
      if (s6_r.op == rmg_pkg::OP_VERTEX) begin
        item.vnum = s6_r.a[15:0];
        item.vx   = sat_x;
        item.vy   = s6_r.y;
        item.vz   = sat_z;
      end else begin
        item.a    = s6_r.a[15:0];
        item.idx1 = s6_r.idx1;
        item.idx2 = s6_r.idx2;
      end
    end
  end

  rmg_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (v_r[5]),
    .item       (item),
    .item_ready (en),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

`ifndef SYNTHESIS
  a_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> v_r[0])
    else $error("accepted transfer did not enter the pipeline");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!en && v_r[5]) |=> v_r[5])
    else $error("item in last stage lost during a stall");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("pipeline stalled with an empty output register");
`endif

endmodule

FILE: design/rmg_emit.sv
// Output register of the mesh generator: holds one finished item and plays a good quad out
// as six triangle-corner transfers. Depends on rmg_pkg.
module rmg_emit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                item_valid,
  input  rmg_pkg::emit_item_t item,
  output logic                item_ready,
  output logic                out_tvalid,
  input  logic                out_tready,
  // vertex_number, vertex_x, vertex_y, vertex_z, triangle_vertex (lowest bit first)
  output logic [127:0]        out_tdata,
  // result_kind, bad_request (lowest bit first)
  output logic [1:0]          out_tuser,
  output logic                out_tlast
);

  logic                valid_r;
  logic [2:0]          beat_r;
  rmg_pkg::emit_item_t item_r;
  logic                last_beat;
  logic [15:0]         tri_vertex;

  assign last_beat = (item_r.kind == rmg_pkg::OP_VERTEX) || item_r.bad ||
                     (beat_r == 3'(rmg_pkg::QUAD_RESULTS - 1));
  assign item_ready = !valid_r || (out_tready && last_beat);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      beat_r  <= 3'd0;
    end else if (item_ready) begin
      valid_r <= item_valid;
      beat_r  <= 3'd0;
    end else if (out_tready) begin
      beat_r <= beat_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      item_r <= item;
    end
  end

  // Corner order of the two triangles: a, a+m, a+m+1, a+m+1, a+1, a (a+m terms modulo n*m).
  always_comb begin
    case (beat_r)
      3'd0:    tri_vertex = item_r.a;
      3'd1:    tri_vertex = item_r.idx1;
      3'd2:    tri_vertex = item_r.idx2;
      3'd3:    tri_vertex = item_r.idx2;
      3'd4:    tri_vertex = item_r.a + 16'd1;
      3'd5:    tri_vertex = item_r.a;
      default: tri_vertex = item_r.a;
    endcase
    if (item_r.kind != rmg_pkg::OP_QUAD || item_r.bad) begin
      tri_vertex = 16'd0;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tlast  = last_beat;
  assign out_tuser  = {item_r.bad, item_r.kind};
  assign out_tdata  = {tri_vertex, item_r.vz, item_r.vy, item_r.vx, item_r.vnum};

`ifndef SYNTHESIS
  a_beat_range: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (beat_r < 3'(rmg_pkg::QUAD_RESULTS)))
    else $error("quad beat counter out of range");

  a_single_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (!out_tuser[0] || out_tuser[1])) |-> out_tlast)
    else $error("vertex or bad result not marked last");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1]) |-> (out_tdata == 128'd0))
    else $error("bad request carries data");
`endif

endmodule
